// File: hw/rtl/s5udp_pkg.sv
`timescale 1ns / 1ps

package s5udp_pkg;

    // Width of the saturating payload byte counter
    localparam int LEN_WIDTH = 16;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int AK_W     = 2;
    localparam int IPV4_W   = 32;
    localparam int PORT_W   = 16;
    localparam int HDR_W    = 9;
    localparam int PLEN_W   = 16;
    localparam int STATUS_W = 3;

    localparam int IPV4_BYTES = IPV4_W / BYTE_W;
    localparam int IPV6_BYTES = 16;

    // Address type codes on the wire
    localparam logic [BYTE_W-1:0] ATYP_IPV4   = 8'h01;
    localparam logic [BYTE_W-1:0] ATYP_DOMAIN = 8'h03;
    localparam logic [BYTE_W-1:0] ATYP_IPV6   = 8'h04;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DOMAIN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd3;

    // Address kinds in the header summary
    localparam logic [AK_W-1:0] AK_IPV4   = 2'd0;
    localparam logic [AK_W-1:0] AK_DOMAIN = 2'd1;
    localparam logic [AK_W-1:0] AK_IPV6   = 2'd2;

    // End status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RSV       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FRAG      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ATYP      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd4;

    typedef enum logic [11:0] {
        PH_RSV0  = 12'b0000_0000_0001,
        PH_RSV1  = 12'b0000_0000_0010,
        PH_FRAG  = 12'b0000_0000_0100,
        PH_ATYP  = 12'b0000_0000_1000,
        PH_IPV4  = 12'b0000_0001_0000,
        PH_DLEN  = 12'b0000_0010_0000,
        PH_DOM   = 12'b0000_0100_0000,
        PH_IPV6  = 12'b0000_1000_0000,
        PH_PORTH = 12'b0001_0000_0000,
        PH_PORTL = 12'b0010_0000_0000,
        PH_PAY   = 12'b0100_0000_0000,
        PH_ERR   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   out_byte;
        logic [AK_W-1:0]     addr_kind;
        logic [IPV4_W-1:0]   ipv4_addr;
        logic [PORT_W-1:0]   dst_port;
        logic [HDR_W-1:0]    header_length;
        logic [PLEN_W-1:0]   payload_length;
        logic [STATUS_W-1:0] status;
        logic                last_of_run;
    } result_t;

    // Result queue: two results per byte plus one waiting at the output
    localparam int QDEPTH = 3;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// File: hw/rtl/s5udp_byte_if.sv
`timescale 1ns / 1ps

interface s5udp_byte_if;
    logic                           valid;
    logic                           ready;
    logic [s5udp_pkg::BYTE_W-1:0]   in_byte;
    logic                           last_byte;

    modport source (output valid, input ready, output in_byte, output last_byte);
    modport sink   (input valid, output ready, input in_byte, input last_byte);
endinterface

// File: hw/rtl/s5udp_result_if.sv
`timescale 1ns / 1ps

interface s5udp_result_if;
    logic                             valid;
    logic                             ready;
    logic [s5udp_pkg::KIND_W-1:0]     kind;
    logic [s5udp_pkg::BYTE_W-1:0]     out_byte;
    logic [s5udp_pkg::AK_W-1:0]       addr_kind;
    logic [s5udp_pkg::IPV4_W-1:0]     ipv4_addr;
    logic [s5udp_pkg::PORT_W-1:0]     dst_port;
    logic [s5udp_pkg::HDR_W-1:0]      header_length;
    logic [s5udp_pkg::PLEN_W-1:0]     payload_length;
    logic [s5udp_pkg::STATUS_W-1:0]   status;
    logic                             last_of_run;

    modport source (
        output valid, input ready,
        output kind, output out_byte, output addr_kind, output ipv4_addr,
        output dst_port, output header_length, output payload_length,
        output status, output last_of_run
    );
    modport sink (
        input valid, output ready,
        input kind, input out_byte, input addr_kind, input ipv4_addr,
        input dst_port, input header_length, input payload_length,
        input status, input last_of_run
    );
endinterface

// File: hw/rtl/socks5_udp_header_deframer.sv
`timescale 1ns / 1ps

// SOCKS5 UDP datagram header deframer.
// rx_chan takes one datagram byte per transfer, last_byte set on the final one.
// tx_chan gives results: domain-name bytes, one header summary after the port,
// payload bytes, and an end status with the payload length on the final byte.
// Each byte is parsed in the cycle it is accepted and its results (zero, one or
// two) are written to a three-entry result queue; the queue head drives tx_chan,
// so each result is registered in the queue before it appears on tx_chan.
// Throughput: one byte per cycle while each byte yields at most one result and
// tx_chan is not stalled; a byte that yields two results (final byte with a data
// result) writes both into the queue at once. rx_chan.ready is high whenever at
// most one result is queued, independent of tx_chan.ready, so a stalled receiver
// backs up at most three results before input is held off.
// Reset empties the queue and returns the parser to the first reserved byte;
// after each final byte the parser returns to that state on its own.
// After a header error the rest of the datagram is dropped until its final
// byte, which reports the error with payload length zero.
module socks5_udp_header_deframer (
    input  logic               clk,
    input  logic               rst_n,
    s5udp_byte_if.sink         rx_chan,
    s5udp_result_if.source     tx_chan
);
    import s5udp_pkg::*;

    localparam logic [HDR_W-1:0]     HDR_MAX = '1;
    localparam logic [LEN_WIDTH-1:0] PAY_MAX = '1;

    // Parser state
    phase_t                 phase_reg, phase_next;
    logic [BYTE_W-1:0]      fcnt_reg, fcnt_next;
    logic [BYTE_W-1:0]      dlen_reg, dlen_next;
    logic [IPV4_W-1:0]      addr_reg, addr_next;
    logic [BYTE_W-1:0]      port_hi_reg, port_hi_next;
    logic [HDR_W-1:0]       hdr_cnt_reg, hdr_cnt_next;
    logic [LEN_WIDTH-1:0]   pay_cnt_reg, pay_cnt_next;
    logic [STATUS_W-1:0]    err_reg, err_next;
    logic [AK_W-1:0]        atyp_reg, atyp_next;

    // Result queue
    result_t                q_mem [QDEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]      cnt_reg, cnt_next;

    logic       accept;
    logic       pop;
    logic       has_data;
    result_t    data_res;
    result_t    end_res;
    logic [QPTR_W-1:0] wr_ptr_inc;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QDEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign rx_chan.ready = (cnt_reg < QCNT_W'(2));
    assign accept        = rx_chan.valid && rx_chan.ready;
    assign pop           = tx_chan.valid && tx_chan.ready;

    always_comb
    begin
        phase_next   = phase_reg;
        fcnt_next    = fcnt_reg;
        dlen_next    = dlen_reg;
        addr_next    = addr_reg;
        port_hi_next = port_hi_reg;
        hdr_cnt_next = hdr_cnt_reg;
        pay_cnt_next = pay_cnt_reg;
        err_next     = err_reg;
        atyp_next    = atyp_reg;
        has_data     = 1'b0;
        data_res     = '0;

        if (phase_reg != PH_PAY && phase_reg != PH_ERR && hdr_cnt_reg != HDR_MAX)
            hdr_cnt_next = hdr_cnt_reg + 1'b1;

        case (phase_reg)
            PH_RSV0, PH_RSV1:
            begin
                if (rx_chan.in_byte != '0)
                begin
                    err_next   = ST_RSV;
                    phase_next = PH_ERR;
                end
                else if (phase_reg == PH_RSV0)
                    phase_next = PH_RSV1;
                else
                    phase_next = PH_FRAG;
            end
            PH_FRAG:
            begin
                if (rx_chan.in_byte != '0)
                begin
                    err_next   = ST_FRAG;
                    phase_next = PH_ERR;
                end
                else
                    phase_next = PH_ATYP;
            end
            PH_ATYP:
            begin
                fcnt_next = '0;
                if (rx_chan.in_byte == ATYP_IPV4)
                begin
                    atyp_next  = AK_IPV4;
                    addr_next  = '0;
                    phase_next = PH_IPV4;
                end
                else if (rx_chan.in_byte == ATYP_DOMAIN)
                begin
                    atyp_next  = AK_DOMAIN;
                    phase_next = PH_DLEN;
                end
                else if (rx_chan.in_byte == ATYP_IPV6)
                begin
                    atyp_next  = AK_IPV6;
                    phase_next = PH_IPV6;
                end
                else
                begin
                    err_next   = ST_ATYP;
                    phase_next = PH_ERR;
                end
            end
            PH_IPV4:
            begin
                addr_next = {addr_reg[IPV4_W-BYTE_W-1:0], rx_chan.in_byte};
                fcnt_next = fcnt_reg + 1'b1;
                if (fcnt_next >= BYTE_W'(IPV4_BYTES))
                    phase_next = PH_PORTH;
            end
            PH_DLEN:
            begin
                dlen_next  = rx_chan.in_byte;
                fcnt_next  = '0;
                phase_next = (rx_chan.in_byte != '0) ? PH_DOM : PH_PORTH;
            end
            PH_DOM:
            begin
                has_data          = 1'b1;
                data_res.kind     = KIND_DOMAIN;
                data_res.out_byte = rx_chan.in_byte;
                fcnt_next         = fcnt_reg + 1'b1;
                if (fcnt_next >= dlen_reg)
                    phase_next = PH_PORTH;
            end
            PH_IPV6:
            begin
                fcnt_next = fcnt_reg + 1'b1;
                if (fcnt_next >= BYTE_W'(IPV6_BYTES))
                    phase_next = PH_PORTH;
            end
            PH_PORTH:
            begin
                port_hi_next = rx_chan.in_byte;
                phase_next   = PH_PORTL;
            end
            PH_PORTL:
            begin
                has_data               = 1'b1;
                data_res.kind          = KIND_SUMMARY;
                data_res.addr_kind     = atyp_reg;
                data_res.ipv4_addr     = (atyp_reg == AK_IPV4) ? addr_reg : '0;
                data_res.dst_port      = {port_hi_reg, rx_chan.in_byte};
                data_res.header_length = hdr_cnt_next;
                phase_next             = PH_PAY;
            end
            PH_PAY:
            begin
                has_data          = 1'b1;
                data_res.kind     = KIND_PAYLOAD;
                data_res.out_byte = rx_chan.in_byte;
                if (pay_cnt_reg != PAY_MAX)
                    pay_cnt_next = pay_cnt_reg + 1'b1;
            end
            default:
            begin
                // error: drop bytes until the final one
            end
        endcase

        data_res.last_of_run = !rx_chan.last_byte;

        end_res             = '0;
        end_res.kind        = KIND_END;
        end_res.last_of_run = 1'b1;
        if (phase_next == PH_ERR)
            end_res.status = err_next;
        else if (phase_next == PH_PAY)
        begin
            end_res.status         = ST_OK;
            end_res.payload_length = PLEN_W'(pay_cnt_next);
        end
        else
            end_res.status = ST_TRUNCATED;
    end

    // Queue pointer and fill count
    always_comb
    begin
        wr_ptr_inc  = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg - QCNT_W'(pop);
        if (accept)
        begin
            if (has_data && rx_chan.last_byte)
            begin
                wr_ptr_next = ptr_inc(wr_ptr_inc);
                cnt_next    = cnt_next + QCNT_W'(2);
            end
            else if (has_data || rx_chan.last_byte)
            begin
                wr_ptr_next = wr_ptr_inc;
                cnt_next    = cnt_next + QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (has_data)
            begin
                q_mem[wr_ptr_reg] <= data_res;
                if (rx_chan.last_byte)
                    q_mem[wr_ptr_inc] <= end_res;
            end
            else if (rx_chan.last_byte)
                q_mem[wr_ptr_reg] <= end_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_RSV0;
            fcnt_reg    <= '0;
            dlen_reg    <= '0;
            addr_reg    <= '0;
            port_hi_reg <= '0;
            hdr_cnt_reg <= '0;
            pay_cnt_reg <= '0;
            err_reg     <= '0;
            atyp_reg    <= '0;
        end
        else if (accept)
        begin
            if (rx_chan.last_byte)
            begin
                // end of datagram: start over for the next one
                phase_reg   <= PH_RSV0;
                fcnt_reg    <= '0;
                dlen_reg    <= '0;
                addr_reg    <= '0;
                port_hi_reg <= '0;
                hdr_cnt_reg <= '0;
                pay_cnt_reg <= '0;
                err_reg     <= '0;
                atyp_reg    <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                fcnt_reg    <= fcnt_next;
                dlen_reg    <= dlen_next;
                addr_reg    <= addr_next;
                port_hi_reg <= port_hi_next;
                hdr_cnt_reg <= hdr_cnt_next;
                pay_cnt_reg <= pay_cnt_next;
                err_reg     <= err_next;
                atyp_reg    <= atyp_next;
            end
        end
    end

    assign tx_chan.valid          = (cnt_reg != '0);
    assign tx_chan.kind           = q_mem[rd_ptr_reg].kind;
    assign tx_chan.out_byte       = q_mem[rd_ptr_reg].out_byte;
    assign tx_chan.addr_kind      = q_mem[rd_ptr_reg].addr_kind;
    assign tx_chan.ipv4_addr      = q_mem[rd_ptr_reg].ipv4_addr;
    assign tx_chan.dst_port       = q_mem[rd_ptr_reg].dst_port;
    assign tx_chan.header_length  = q_mem[rd_ptr_reg].header_length;
    assign tx_chan.payload_length = q_mem[rd_ptr_reg].payload_length;
    assign tx_chan.status         = q_mem[rd_ptr_reg].status;
    assign tx_chan.last_of_run    = q_mem[rd_ptr_reg].last_of_run;

endmodule
